### rtl/core/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants of the feedback sequencer
// Phase and display codes, configuration layout, and the result record.
// ----------------------------------------------------------------------------
package sts_pkg;

	localparam int WINDOW_DEF      = 8;
	localparam int SAMPLE_BITS_DEF = 10;

	localparam int THR_BITS     = 10;
	localparam int TICK_BITS    = 16;
	localparam int AVG_BITS     = 10;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_THRESHOLD = 3'd0,
		CFG_GREEN     = 3'd1,
		CFG_LISTEN    = 3'd2,
		CFG_FACE      = 3'd3,
		CFG_RED       = 3'd4
	} cfg_index_t;

	localparam logic [THR_BITS-1:0]  THRESHOLD_RST = 10'd512;
	localparam logic [TICK_BITS-1:0] GREEN_RST     = 16'd200;
	localparam logic [TICK_BITS-1:0] LISTEN_RST    = 16'd300;
	localparam logic [TICK_BITS-1:0] FACE_RST      = 16'd50;
	localparam logic [TICK_BITS-1:0] RED_RST       = 16'd200;

	typedef enum logic [1:0] {
		PH_GREEN  = 2'd0,
		PH_LISTEN = 2'd1,
		PH_FACE   = 2'd2,
		PH_RED    = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		PAT_OFF   = 2'd0,
		PAT_GREEN = 2'd1,
		PAT_FACE  = 2'd2,
		PAT_RED   = 2'd3
	} pattern_t;

	typedef struct packed {
		logic [THR_BITS-1:0]  threshold;
		logic [TICK_BITS-1:0] green_ticks;
		logic [TICK_BITS-1:0] listen_ticks;
		logic [TICK_BITS-1:0] face_ticks;
		logic [TICK_BITS-1:0] red_ticks;
	} cfg_t;

	// Window control from the sequencer.
	typedef struct packed {
		logic push;
		logic clear;
	} win_ctl_t;

	typedef struct packed {
		logic                write;
		pattern_t            pattern;
		phase_t              phase;
		logic [AVG_BITS-1:0] average;
		logic                goal;
	} res_t;

endpackage

### rtl/core/sts_cell.sv
// ----------------------------------------------------------------------------
// sts_cell: one stage of the sample window
// Holds one sample and passes it to the next stage on each shift.
// ----------------------------------------------------------------------------
module sts_cell #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   shift,
	input  logic                   clear,
	input  logic [SAMPLE_BITS-1:0] d,
	output logic [SAMPLE_BITS-1:0] q
);

	logic [SAMPLE_BITS-1:0] sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (clear) begin
			sample_q <= '0;
		end else if (shift) begin
			sample_q <= d;
		end
	end

	assign q = sample_q;

endmodule

### rtl/core/sts_window.sv
// ----------------------------------------------------------------------------
// sts_window: moving-average window
// A chain of sample cells with a running sum; the floor average is taken
// by an exact reciprocal multiply.
// ----------------------------------------------------------------------------
module sts_window
	import sts_pkg::*;
#(
	parameter int WINDOW      = WINDOW_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  win_ctl_t               ctl,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic [SAMPLE_BITS-1:0] avg_next,
	output logic [SAMPLE_BITS-1:0] avg_last
);

	localparam int LOGW   = $clog2(WINDOW);
	localparam int SUMW   = SAMPLE_BITS + LOGW;
	localparam int SHIFT  = SUMW + LOGW;
	localparam int RECIPW = SUMW + 1;
	localparam int PRODW  = SUMW + RECIPW;
	// Rounded-up reciprocal; with this shift the quotient is exact for any sum.
	localparam logic [63:0] RECIP_WIDE =
		((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
	localparam logic [RECIPW-1:0] RECIP = RECIP_WIDE[RECIPW-1:0];

	logic [SAMPLE_BITS-1:0] tap [WINDOW+1];
	logic [SUMW-1:0]        sum_q;
	logic [SUMW-1:0]        sum_next;
	logic [PRODW-1:0]       prod;
	logic [SAMPLE_BITS-1:0] avg_q;

	assign tap[0] = sample;

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		sts_cell #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.shift (ctl.push),
			.clear (ctl.clear),
			.d     (tap[i]),
			.q     (tap[i+1])
		);
	end

	assign sum_next = sum_q - SUMW'(tap[WINDOW]) + SUMW'(sample);
	assign prod     = PRODW'(sum_next) * PRODW'(RECIP);
	assign avg_next = prod[SHIFT +: SAMPLE_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			avg_q <= '0;
		end else if (ctl.clear) begin
			sum_q <= '0;
		end else if (ctl.push) begin
			sum_q <= sum_next;
			avg_q <= avg_next;
		end
	end

	assign avg_last = avg_q;

endmodule

### rtl/core/sts_seq.sv
// ----------------------------------------------------------------------------
// sts_seq: phase sequencer
// Moves through the green, listen, face and red phases on accepted ticks
// and builds the result record of each tick.
// ----------------------------------------------------------------------------
module sts_seq
	import sts_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  cfg_t                   cfg,
	input  logic [SAMPLE_BITS-1:0] avg_next,
	input  logic [SAMPLE_BITS-1:0] avg_last,
	output win_ctl_t               ctl,
	output res_t                   res
);

	localparam int CMPW = (SAMPLE_BITS > AVG_BITS) ? SAMPLE_BITS : AVG_BITS;

	phase_t               phase_q, phase_d;
	logic [TICK_BITS-1:0] cnt_q, cnt_d;
	logic                 green_ent_q, green_ent_d;
	logic                 face_ent_q, face_ent_d;
	logic                 red_ent_q, red_ent_d;
	logic                 goal_q, goal_d;

	logic [TICK_BITS-1:0] cnt_base, cnt_bump, limit;
	logic [CMPW-1:0]      avg_next_ext, avg_shown_ext;
	logic                 hit, done;
	logic                 write;
	pattern_t             pattern;

	assign avg_next_ext = CMPW'(avg_next);
	assign hit          = avg_next_ext >= CMPW'(cfg.threshold);

	// Green and red restart the count on their first tick.
	assign cnt_base = (((phase_q == PH_GREEN) && !green_ent_q) ||
	                   ((phase_q == PH_RED) && !red_ent_q)) ? '0 : cnt_q;
	assign cnt_bump = (cnt_base == TICK_MAX) ? cnt_base : cnt_base + 1'b1;

	always_comb begin
		case (phase_q)
			PH_GREEN:  limit = cfg.green_ticks;
			PH_LISTEN: limit = cfg.listen_ticks;
			PH_FACE:   limit = cfg.face_ticks;
			default:   limit = cfg.red_ticks;
		endcase
	end

	assign done = cnt_bump >= limit;

	// Next state.
	always_comb begin
		phase_d     = phase_q;
		cnt_d       = cnt_q;
		green_ent_d = green_ent_q;
		face_ent_d  = face_ent_q;
		red_ent_d   = red_ent_q;
		goal_d      = goal_q;
		if (fire) begin
			unique case (phase_q)
				PH_GREEN: begin
					green_ent_d = 1'b1;
					cnt_d       = cnt_bump;
					if (done) begin
						green_ent_d = 1'b0;
						phase_d     = PH_LISTEN;
						cnt_d       = '0;
					end
				end
				PH_LISTEN: begin
					if (hit) begin
						goal_d  = 1'b1;
						cnt_d   = '0;
						phase_d = PH_FACE;
					end else begin
						cnt_d = cnt_bump;
						if (done) begin
							if (goal_q) begin
								phase_d = PH_GREEN;
								goal_d  = 1'b0;
							end else begin
								phase_d = PH_RED;
							end
						end
					end
				end
				PH_FACE: begin
					face_ent_d = 1'b1;
					if (hit) begin
						cnt_d = '0;
					end else if (done) begin
						phase_d    = PH_LISTEN;
						face_ent_d = 1'b0;
						cnt_d      = '0;
					end else begin
						cnt_d = cnt_bump;
					end
				end
				PH_RED: begin
					red_ent_d = 1'b1;
					cnt_d     = cnt_bump;
					if (done) begin
						red_ent_d = 1'b0;
						phase_d   = PH_GREEN;
					end
				end
			endcase
		end
	end

	// Outputs.
	always_comb begin
		write     = 1'b0;
		pattern   = PAT_OFF;
		ctl.push  = 1'b0;
		ctl.clear = 1'b0;
		unique case (phase_q)
			PH_GREEN: begin
				write     = !green_ent_q;
				pattern   = green_ent_q ? PAT_OFF : PAT_GREEN;
				ctl.clear = fire && done;
			end
			PH_LISTEN: begin
				write    = 1'b1;
				ctl.push = fire;
			end
			PH_FACE: begin
				write    = !face_ent_q;
				pattern  = face_ent_q ? PAT_OFF : PAT_FACE;
				ctl.push = fire;
			end
			PH_RED: begin
				write   = !red_ent_q;
				pattern = red_ent_q ? PAT_OFF : PAT_RED;
			end
		endcase
	end

	assign avg_shown_ext = ctl.push ? avg_next_ext : CMPW'(avg_last);

	assign res.write   = write;
	assign res.pattern = pattern;
	assign res.phase   = phase_d;
	assign res.average = avg_shown_ext[AVG_BITS-1:0];
	assign res.goal    = goal_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_GREEN;
			cnt_q       <= '0;
			green_ent_q <= 1'b0;
			face_ent_q  <= 1'b0;
			red_ent_q   <= 1'b0;
			goal_q      <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			cnt_q       <= cnt_d;
			green_ent_q <= green_ent_d;
			face_ent_q  <= face_ent_d;
			red_ent_q   <= red_ent_d;
			goal_q      <= goal_d;
		end
	end

endmodule

### rtl/core/sts_out_buf.sv
// ----------------------------------------------------------------------------
// sts_out_buf: result output register with skid stage
// Lets one more item in while the receiver stalls on a waiting result.
// ----------------------------------------------------------------------------
module sts_out_buf
	import sts_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_res,
	output logic ready,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	res_t main_q, skid_q;
	logic main_valid_q, skid_valid_q;
	logic pop;

	assign ready     = !skid_valid_q;
	assign pop       = main_valid_q && out_ready;
	assign out_valid = main_valid_q;
	assign out_res   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!main_valid_q || pop) begin
				main_valid_q <= skid_valid_q || push;
				skid_valid_q <= 1'b0;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!main_valid_q || pop) begin
			main_q <= skid_valid_q ? skid_q : push_res;
		end else if (push) begin
			skid_q <= push_res;
		end
	end

endmodule

### rtl/core/sound_triggered_feedback_sequencer.sv
// ----------------------------------------------------------------------------
// sound_triggered_feedback_sequencer: sound-triggered display sequencer
// Time-base ticks carrying envelope samples drive a green/listen/face/red
// cycle and produce one display result per tick.
// ----------------------------------------------------------------------------
// Usage:
//   Each item on the input channel (in_valid/in_ready, field sample) is one
//   time-base tick. Every accepted item yields exactly one result item on the
//   output channel (out_valid/out_ready): a display command flag and pattern,
//   the phase after the tick, the latest window average and the goal flag.
//   Each result is registered before out_valid shows it. One item per cycle
//   is taken while the receiver keeps up; the running sum, the reciprocal
//   multiply for the average and the threshold compare are combinational.
//   When the receiver stalls, one further item is taken into a skid stage,
//   after which in_ready stays low until the waiting result is taken.
//   Asynchronous reset puts the block in the green phase with an empty window,
//   zero counters and the default register values; no result is pending.
//   Register writes on cfg_write, cfg_index, cfg_data ignore unknown indexes;
//   the user must write only while no item is in flight; this is not enforced.
// ----------------------------------------------------------------------------
module sound_triggered_feedback_sequencer
	import sts_pkg::*;
#(
	parameter int WINDOW      = WINDOW_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [SAMPLE_BITS-1:0]   sample,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     display_write,
	output logic [1:0]               display_pattern,
	output logic [1:0]               phase_after,
	output logic [AVG_BITS-1:0]      average_level,
	output logic                     goal_reached
);

	cfg_t                   cfg_q;
	win_ctl_t               win_ctl;
	logic [SAMPLE_BITS-1:0] avg_next, avg_last;
	res_t                   step_res, out_res;
	logic                   fire;

	assign fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold    <= THRESHOLD_RST;
			cfg_q.green_ticks  <= GREEN_RST;
			cfg_q.listen_ticks <= LISTEN_RST;
			cfg_q.face_ticks   <= FACE_RST;
			cfg_q.red_ticks    <= RED_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_THRESHOLD: cfg_q.threshold    <= cfg_data[THR_BITS-1:0];
				CFG_GREEN:     cfg_q.green_ticks  <= cfg_data[TICK_BITS-1:0];
				CFG_LISTEN:    cfg_q.listen_ticks <= cfg_data[TICK_BITS-1:0];
				CFG_FACE:      cfg_q.face_ticks   <= cfg_data[TICK_BITS-1:0];
				CFG_RED:       cfg_q.red_ticks    <= cfg_data[TICK_BITS-1:0];
				default: ;
			endcase
		end
	end

	sts_window #(
		.WINDOW     (WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (win_ctl),
		.sample  (sample),
		.avg_next(avg_next),
		.avg_last(avg_last)
	);

	sts_seq #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.cfg     (cfg_q),
		.avg_next(avg_next),
		.avg_last(avg_last),
		.ctl     (win_ctl),
		.res     (step_res)
	);

	sts_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fire),
		.push_res (step_res),
		.ready    (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_res  (out_res)
	);

	assign display_write   = out_res.write;
	assign display_pattern = out_res.pattern;
	assign phase_after     = out_res.phase;
	assign average_level   = out_res.average;
	assign goal_reached    = out_res.goal;

endmodule

### rtl/core/sts_checker.sv
// ----------------------------------------------------------------------------
// sts_checker: port-level checks of the feedback sequencer
// Watches the output channel and the result fields over time.
// ----------------------------------------------------------------------------
module sts_checker
	import sts_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic                display_write,
	input logic [1:0]          display_pattern,
	input logic [1:0]          phase_after,
	input logic [AVG_BITS-1:0] average_level,
	input logic                goal_reached
);

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
			$stable({display_write, display_pattern, phase_after,
			         average_level, goal_reached}))
		else $error("result changed while stalled");

	// Input back-pressure only comes from a full output side.
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result waiting");

	// Without a display command the pattern reads as off.
	a_pattern_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !display_write |-> display_pattern == PAT_OFF)
		else $error("pattern set without display command");

	// The face phase is only reached once the goal is met.
	a_face_goal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && phase_after == PH_FACE |-> goal_reached)
		else $error("face phase without goal");

endmodule

bind sound_triggered_feedback_sequencer sts_checker u_sts_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.display_write  (display_write),
	.display_pattern(display_pattern),
	.phase_after    (phase_after),
	.average_level  (average_level),
	.goal_reached   (goal_reached)
);
